@@ hw/rtl/dll_pkg.sv @@
// Shared types and constants for the doubly linked list engine.
// Holds beat structs, command and status codes, cell and processor controls.
// No dependencies.
`timescale 1ns / 1ps

package dll_pkg;

    // Default pool size and fixed field widths.
    localparam int DEFAULT_NODES = 32;
    localparam int VAL_W         = 32;
    localparam int CMD_W         = 3;
    localparam int STATUS_W      = 2;
    localparam int OUT_CNT_W     = 6;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PREPEND = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FWD     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_BWD     = 3'd5;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic signed [VAL_W-1:0] value;
        logic signed [VAL_W-1:0] key;
    } in_beat_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [VAL_W-1:0] item;
        logic                    last;
        logic [OUT_CNT_W-1:0]    count;
    } out_beat_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_PASS_L,
        S_PASS_R,
        S_RESP
    } state_t;

    // What a cell loads at the next edge.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_FROM_RIGHT,
        CELL_FROM_LEFT,
        CELL_LOAD
    } cell_op_t;

    // Edit processor modes during a rotation pass.
    typedef enum logic [1:0] {
        P_PASS,
        P_DELAY,
        P_SKIP
    } proc_mode_t;

    // Control group from the sequencer to the edit processor.
    typedef struct packed {
        logic start;      // new command accepted, clear mode and match flag
        logic step;       // ring rotates one position this cycle
        logic srch;       // compare the head element against the target
        logic ins_ok;     // a match opens a slot for the new value
        logic del;        // a match removes the element
        logic elem_valid; // the head element belongs to the list
    } proc_ctrl_t;

endpackage

@@ hw/rtl/dll_cell.sv @@
// One storage cell of the list ring: holds one element value.
// Depends on dll_pkg for the cell operation type.
`timescale 1ns / 1ps

module dll_cell (
    input  logic                             clk,
    input  dll_pkg::cell_op_t                op,
    input  logic signed [dll_pkg::VAL_W-1:0] from_left,
    input  logic signed [dll_pkg::VAL_W-1:0] from_right,
    input  logic signed [dll_pkg::VAL_W-1:0] load_data,
    output logic signed [dll_pkg::VAL_W-1:0] val
);

    logic signed [dll_pkg::VAL_W-1:0] val_reg;
    logic signed [dll_pkg::VAL_W-1:0] val_next;

    // Select the neighbor, the new value, or hold.
    always_comb
    begin
        case (op)
            dll_pkg::CELL_FROM_RIGHT: val_next = from_right;
            dll_pkg::CELL_FROM_LEFT:  val_next = from_left;
            dll_pkg::CELL_LOAD:       val_next = load_data;
            default:                  val_next = val_reg;
        endcase
    end

    // Payload register, no reset needed.
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

@@ hw/rtl/dll_proc.sv @@
// Edit processor at the wrap point of the ring.
// Passes, inserts after, or removes the first matching element as the ring rotates.
// Depends on dll_pkg.
`timescale 1ns / 1ps

module dll_proc (
    input  logic                             clk,
    input  logic                             rst_n,
    input  dll_pkg::proc_ctrl_t              ctrl,
    input  logic signed [dll_pkg::VAL_W-1:0] head_val,
    input  logic signed [dll_pkg::VAL_W-1:0] next_val,
    input  logic signed [dll_pkg::VAL_W-1:0] target,
    input  logic signed [dll_pkg::VAL_W-1:0] new_val,
    output logic signed [dll_pkg::VAL_W-1:0] out_val,
    output logic                             found_now
);

    dll_pkg::proc_mode_t              mode_reg;
    dll_pkg::proc_mode_t              mode_next;
    logic                             found_reg;
    logic                             found_next;
    logic signed [dll_pkg::VAL_W-1:0] hold_reg;
    logic signed [dll_pkg::VAL_W-1:0] hold_next;
    logic                             match;

    // Only the first list element equal to the target counts.
    assign match = ctrl.srch && ctrl.elem_valid && !found_reg &&
                   (mode_reg == dll_pkg::P_PASS) && (head_val == target);
    assign found_now = found_reg || match;

    // Output stream and mode transitions.
    always_comb
    begin
        mode_next  = mode_reg;
        found_next = found_reg;
        hold_next  = hold_reg;
        case (mode_reg)
            dll_pkg::P_DELAY: out_val = hold_reg;
            dll_pkg::P_SKIP:  out_val = next_val;
            default:          out_val = (match && ctrl.del) ? next_val : head_val;
        endcase

        if (ctrl.start)
        begin
            mode_next  = dll_pkg::P_PASS;
            found_next = 1'b0;
        end
        else if (ctrl.step)
        begin
            case (mode_reg)
                dll_pkg::P_DELAY:
                begin
                    // Everything behind the new node slides back by one.
                    hold_next = head_val;
                end
                dll_pkg::P_SKIP:
                begin
                    mode_next = dll_pkg::P_SKIP;
                end
                default:
                begin
                    if (match)
                    begin
                        found_next = 1'b1;
                        if (ctrl.ins_ok)
                        begin
                            mode_next = dll_pkg::P_DELAY;
                            hold_next = new_val;
                        end
                        else if (ctrl.del)
                        begin
                            mode_next = dll_pkg::P_SKIP;
                        end
                    end
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= dll_pkg::P_PASS;
            found_reg <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            found_reg <= found_next;
        end
    end

    // Held element while the stream runs one position late.
    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule

@@ hw/rtl/doubly_linked_list_engine_unit.sv @@
// Top level of the doubly linked list engine: a ring of value cells,
// an edit processor at the wrap point and the command sequencer.
// Depends on dll_pkg, dll_cell and dll_proc.
//
//   Channel | Signals                      | Beat type
//   --------+------------------------------+---------------------
//   input   | in_valid, in_ready, in_beat   | dll_pkg::in_beat_t
//   output  | out_valid, out_ready, out_beat| dll_pkg::out_beat_t
//
// The list is kept in list order in a ring of NODES cells, head in cell 0.
// Append and prepend are accepted and then answered with a status beat. Insert and
// delete rotate the ring once and end with a status beat; a walk rotates the ring
// once, or only answers with a status beat on an empty list. While a new beat finds
// the output register still occupied, the sequencer waits. Reset empties the list at
// once; no clearing pass is needed.
`timescale 1ns / 1ps

module doubly_linked_list_engine_unit #(
    parameter int NODES = dll_pkg::DEFAULT_NODES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dll_pkg::in_beat_t  in_beat,
    output logic               out_valid,
    input  logic               out_ready,
    output dll_pkg::out_beat_t out_beat
);

    localparam int CNT_W  = $clog2(NODES + 1);
    localparam int IDX_W  = $clog2(NODES);
    localparam int OCNT_W = dll_pkg::OUT_CNT_W;
    localparam int VW     = dll_pkg::VAL_W;

    dll_pkg::state_t           state_reg;
    dll_pkg::state_t           state_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [IDX_W-1:0]          k_reg;
    logic [IDX_W-1:0]          k_next;
    logic [dll_pkg::CMD_W-1:0] cmd_reg;
    logic [dll_pkg::CMD_W-1:0] cmd_next;
    logic signed [VW-1:0]      value_reg;
    logic signed [VW-1:0]      value_next;
    logic signed [VW-1:0]      key_reg;
    logic signed [VW-1:0]      key_next;
    logic [dll_pkg::STATUS_W-1:0] status_reg;
    logic [dll_pkg::STATUS_W-1:0] status_next;
    logic                      out_valid_reg;
    dll_pkg::out_beat_t        out_beat_reg;
    dll_pkg::out_beat_t        out_beat_next;
    logic                      out_load;

    logic signed [VW-1:0]      cell_val [NODES];
    dll_pkg::cell_op_t         cell_op [NODES];
    logic signed [VW-1:0]      left_in0;
    logic signed [VW-1:0]      proc_out;
    logic                      found_now;
    dll_pkg::proc_ctrl_t       proc_ctrl;

    logic                      out_free;
    logic                      full;
    logic                      elem_valid;
    logic                      last_step;
    logic                      fwd_last;
    logic [IDX_W-1:0]          ridx;
    logic                      ridx_valid;
    logic                      emit;
    logic                      advance;

    // Position decodes for the current rotation step.
    assign out_free   = !out_valid_reg || out_ready;
    assign full       = (count_reg == CNT_W'(NODES));
    assign elem_valid = (CNT_W'(k_reg) < count_reg);
    assign last_step  = (k_reg == IDX_W'(NODES - 1));
    assign fwd_last   = (CNT_W'(CNT_W'(k_reg) + CNT_W'(1)) == count_reg);
    assign ridx       = IDX_W'(NODES - 1) - k_reg;
    assign ridx_valid = (CNT_W'(ridx) < count_reg);
    assign in_ready   = (state_reg == dll_pkg::S_IDLE);

    // Ring of cells.
    genvar gi;
    generate
        for (gi = 0; gi < NODES; gi++)
        begin : g_cell
            logic signed [VW-1:0] left_v;
            logic signed [VW-1:0] right_v;
            if (gi == 0)
            begin : g_first
                assign left_v = left_in0;
            end
            else
            begin : g_mid_l
                assign left_v = cell_val[gi-1];
            end
            if (gi == NODES - 1)
            begin : g_last
                assign right_v = proc_out;
            end
            else
            begin : g_mid_r
                assign right_v = cell_val[gi+1];
            end
            dll_cell u_cell (
                .clk        (clk),
                .op         (cell_op[gi]),
                .from_left  (left_v),
                .from_right (right_v),
                .load_data  (value_reg),
                .val        (cell_val[gi])
            );
        end
    endgenerate

    // Edit processor at the wrap point.
    dll_proc u_proc (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (proc_ctrl),
        .head_val  (cell_val[0]),
        .next_val  (cell_val[1]),
        .target    ((cmd_reg == dll_pkg::CMD_INSERT) ? key_reg : value_reg),
        .new_val   (value_reg),
        .out_val   (proc_out),
        .found_now (found_now)
    );

    // Sequencer: next state, cell operations and result beats.
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        k_next        = k_reg;
        cmd_next      = cmd_reg;
        value_next    = value_reg;
        key_next      = key_reg;
        status_next   = status_reg;
        out_load      = 1'b0;
        out_beat_next = '0;
        left_in0      = cell_val[NODES-1];
        emit          = 1'b0;
        advance       = 1'b0;
        proc_ctrl     = '0;
        for (int i = 0; i < NODES; i++)
        begin
            cell_op[i] = dll_pkg::CELL_HOLD;
        end

        case (state_reg)
            dll_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next        = in_beat.cmd;
                    value_next      = in_beat.value;
                    key_next        = in_beat.key;
                    k_next          = '0;
                    proc_ctrl.start = 1'b1;
                    case (in_beat.cmd)
                        dll_pkg::CMD_APPEND, dll_pkg::CMD_PREPEND:
                        begin
                            status_next = full ? dll_pkg::ST_FULL : dll_pkg::ST_OK;
                            state_next  = dll_pkg::S_RESP;
                        end
                        dll_pkg::CMD_INSERT, dll_pkg::CMD_DELETE:
                        begin
                            state_next = dll_pkg::S_PASS_L;
                        end
                        dll_pkg::CMD_FWD, dll_pkg::CMD_BWD:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = dll_pkg::ST_EMPTY;
                                state_next  = dll_pkg::S_RESP;
                            end
                            else if (in_beat.cmd == dll_pkg::CMD_FWD)
                            begin
                                state_next = dll_pkg::S_PASS_L;
                            end
                            else
                            begin
                                state_next = dll_pkg::S_PASS_R;
                            end
                        end
                        default:
                        begin
                            state_next = dll_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            dll_pkg::S_PASS_L:
            begin
                // Rotate toward the head; the head element is seen by the processor.
                emit    = (cmd_reg == dll_pkg::CMD_FWD) && elem_valid;
                advance = !emit || out_free;
                proc_ctrl.step       = advance;
                proc_ctrl.srch       = (cmd_reg == dll_pkg::CMD_INSERT) ||
                                       (cmd_reg == dll_pkg::CMD_DELETE);
                proc_ctrl.ins_ok     = (cmd_reg == dll_pkg::CMD_INSERT) && !full;
                proc_ctrl.del        = (cmd_reg == dll_pkg::CMD_DELETE);
                proc_ctrl.elem_valid = elem_valid;
                if (advance)
                begin
                    for (int i = 0; i < NODES; i++)
                    begin
                        cell_op[i] = dll_pkg::CELL_FROM_RIGHT;
                    end
                    k_next = IDX_W'(k_reg + IDX_W'(1));
                    if (emit)
                    begin
                        out_load             = 1'b1;
                        out_beat_next.status = dll_pkg::ST_OK;
                        out_beat_next.item   = cell_val[0];
                        out_beat_next.last   = fwd_last;
                        out_beat_next.count  = OCNT_W'(count_reg);
                    end
                    if (last_step)
                    begin
                        if (cmd_reg == dll_pkg::CMD_FWD)
                        begin
                            state_next = dll_pkg::S_IDLE;
                        end
                        else
                        begin
                            state_next = dll_pkg::S_RESP;
                            if (!found_now)
                            begin
                                status_next = dll_pkg::ST_NOT_FOUND;
                            end
                            else if (cmd_reg == dll_pkg::CMD_DELETE)
                            begin
                                status_next = dll_pkg::ST_OK;
                                count_next  = CNT_W'(count_reg - CNT_W'(1));
                            end
                            else if (full)
                            begin
                                status_next = dll_pkg::ST_FULL;
                            end
                            else
                            begin
                                status_next = dll_pkg::ST_OK;
                                count_next  = CNT_W'(count_reg + CNT_W'(1));
                            end
                        end
                    end
                end
            end

            dll_pkg::S_PASS_R:
            begin
                // Rotate toward the tail; the last cell shows elements tail first.
                emit    = ridx_valid;
                advance = !emit || out_free;
                if (advance)
                begin
                    for (int i = 0; i < NODES; i++)
                    begin
                        cell_op[i] = dll_pkg::CELL_FROM_LEFT;
                    end
                    k_next = IDX_W'(k_reg + IDX_W'(1));
                    if (emit)
                    begin
                        out_load             = 1'b1;
                        out_beat_next.status = dll_pkg::ST_OK;
                        out_beat_next.item   = cell_val[NODES-1];
                        out_beat_next.last   = last_step;
                        out_beat_next.count  = OCNT_W'(count_reg);
                    end
                    if (last_step)
                    begin
                        state_next = dll_pkg::S_IDLE;
                    end
                end
            end

            dll_pkg::S_RESP:
            begin
                // Single status beat; append and prepend commit here.
                if (out_free)
                begin
                    if (status_reg == dll_pkg::ST_OK)
                    begin
                        if (cmd_reg == dll_pkg::CMD_APPEND)
                        begin
                            for (int i = 0; i < NODES; i++)
                            begin
                                if (CNT_W'(i) == count_reg)
                                begin
                                    cell_op[i] = dll_pkg::CELL_LOAD;
                                end
                            end
                            count_next = CNT_W'(count_reg + CNT_W'(1));
                        end
                        else if (cmd_reg == dll_pkg::CMD_PREPEND)
                        begin
                            left_in0 = value_reg;
                            for (int i = 0; i < NODES; i++)
                            begin
                                cell_op[i] = dll_pkg::CELL_FROM_LEFT;
                            end
                            count_next = CNT_W'(count_reg + CNT_W'(1));
                        end
                    end
                    out_load             = 1'b1;
                    out_beat_next.status = status_reg;
                    out_beat_next.item   = '0;
                    out_beat_next.last   = 1'b1;
                    out_beat_next.count  = OCNT_W'(count_next);
                    state_next           = dll_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = dll_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dll_pkg::S_IDLE;
            count_reg     <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            k_reg     <= k_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Command and result payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        value_reg  <= value_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        if (out_load)
        begin
            out_beat_reg <= out_beat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

endmodule

@@ sim/tb_doubly_linked_list_engine_unit.sv @@
// Self-checking testbench for the doubly linked list engine top level.
// Mirrors the list in a queue, predicts every reply beat and checks them in order.
// Depends on dll_pkg and doubly_linked_list_engine_unit.
`timescale 1ns / 1ps

module tb_doubly_linked_list_engine_unit;

    localparam int POOL        = dll_pkg::DEFAULT_NODES;
    localparam int VW          = dll_pkg::VAL_W;
    localparam int CW          = dll_pkg::CMD_W;
    localparam int OCW         = dll_pkg::OUT_CNT_W;
    localparam int MIX_ITEMS   = 64;
    localparam int MAX_REPORTS = 100;
    localparam longint LIMIT_NS = 3_000_000;

    // Command codes the engine must ignore.
    localparam logic [CW-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CW-1:0] CMD_SPARE_B = 3'd7;

    localparam logic signed [VW-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VW-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    dll_pkg::in_beat_t  in_beat;
    logic               out_valid;
    logic               out_ready;
    dll_pkg::out_beat_t out_beat;

    // Shadow copy of the list in list order, head first.
    logic signed [VW-1:0] mirror_list[$];
    // Reply beats still owed by the engine, oldest first.
    dll_pkg::out_beat_t expected_replies[$];

    bit src_gaps_on;
    bit sink_stalls_on;
    int fail_cnt;
    int cmds_sent;
    int beats_checked;
    int full_seen;
    int missing_seen;
    int empty_seen;

    doubly_linked_list_engine_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_beat   (in_beat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_beat  (out_beat)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #(LIMIT_NS);
        $error("timeout with %0d reply beats outstanding", expected_replies.size());
        $display("*** FAILED ***");
        $finish;
    end

    // Idle length: mostly none, sometimes short, rarely long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Data values: extremes, a small set that repeats, or anything.
    function automatic logic signed [VW-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            case ($urandom_range(0, 3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        else if (r < 4)
            return $urandom_range(0, 7);
        return $urandom;
    endfunction

    // Position of the first node holding v, or -1.
    function automatic int find_first(input logic signed [VW-1:0] v);
        foreach (mirror_list[i])
            if (mirror_list[i] == v)
                return i;
        return -1;
    endfunction

    function automatic logic signed [VW-1:0] pick_absent();
        logic signed [VW-1:0] v;
        do
            v = $urandom;
        while (find_first(v) >= 0);
        return v;
    endfunction

    // Mostly a value already in the list, otherwise any data value.
    function automatic logic signed [VW-1:0] pick_present();
        if (mirror_list.size() != 0 && $urandom_range(0, 3) != 0)
            return mirror_list[$urandom_range(0, mirror_list.size() - 1)];
        return pick_value();
    endfunction

    // Apply one command to the shadow list and queue the replies it owes.
    function automatic void apply_list_cmd(input dll_pkg::in_beat_t b);
        dll_pkg::out_beat_t r;
        int pos;
        int n;
        r = '0;
        r.last = 1'b1;
        r.status = dll_pkg::ST_OK;
        case (b.cmd)
            dll_pkg::CMD_APPEND, dll_pkg::CMD_PREPEND:
            begin
                if (mirror_list.size() >= POOL)
                    r.status = dll_pkg::ST_FULL;
                else if (b.cmd == dll_pkg::CMD_APPEND)
                    mirror_list.push_back(b.value);
                else
                    mirror_list.push_front(b.value);
            end
            dll_pkg::CMD_INSERT:
            begin
                pos = find_first(b.key);
                if (pos < 0)
                    r.status = dll_pkg::ST_NOT_FOUND;
                else if (mirror_list.size() >= POOL)
                    r.status = dll_pkg::ST_FULL;
                else
                    mirror_list.insert(pos + 1, b.value);
            end
            dll_pkg::CMD_DELETE:
            begin
                pos = find_first(b.value);
                if (pos < 0)
                    r.status = dll_pkg::ST_NOT_FOUND;
                else
                    mirror_list.delete(pos);
            end
            dll_pkg::CMD_FWD, dll_pkg::CMD_BWD:
            begin
                n = mirror_list.size();
                if (n == 0)
                    r.status = dll_pkg::ST_EMPTY;
                else
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        r.item = (b.cmd == dll_pkg::CMD_FWD) ? mirror_list[i]
                                                             : mirror_list[n - 1 - i];
                        r.last = (i == n - 1);
                        r.count = OCW'(n);
                        expected_replies.push_back(r);
                    end
                    return;
                end
            end
            default:
                return;
        endcase
        r.count = OCW'(mirror_list.size());
        expected_replies.push_back(r);
    endfunction

    // Present one command beat and hold it until the engine takes it.
    task automatic send_cmd(input logic [CW-1:0] c, input logic signed [VW-1:0] v,
                            input logic signed [VW-1:0] k);
        int gap;
        gap = src_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        in_beat.cmd = c;
        in_beat.value = v;
        in_beat.key = k;
        do
            @(posedge clk);
        while (!in_ready);
        apply_list_cmd(in_beat);
        cmds_sent++;
    endtask

    task automatic stop_sending();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Walks, deletes and inserts on an empty list.
    task automatic test_empty_list();
        src_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        send_cmd(dll_pkg::CMD_FWD, $urandom, $urandom);
        send_cmd(dll_pkg::CMD_BWD, $urandom, $urandom);
        send_cmd(dll_pkg::CMD_DELETE, 32'sd0, $urandom);
        send_cmd(dll_pkg::CMD_INSERT, 32'sd1, 32'sd0);
    endtask

    // Edits at head, tail and middle, misses, duplicates and spare codes.
    task automatic test_directed_edits();
        src_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
        send_cmd(dll_pkg::CMD_APPEND, VAL_MAX, $urandom);
        send_cmd(dll_pkg::CMD_PREPEND, VAL_MIN, $urandom);
        send_cmd(dll_pkg::CMD_APPEND, -32'sd1, $urandom);
        // Insert after the tail, then after the head.
        send_cmd(dll_pkg::CMD_INSERT, 32'sd0, -32'sd1);
        send_cmd(dll_pkg::CMD_INSERT, 32'sd1, VAL_MIN);
        send_cmd(dll_pkg::CMD_INSERT, 32'sd2, 32'sd12345);
        send_cmd(dll_pkg::CMD_DELETE, 32'sd99, $urandom);
        send_cmd(dll_pkg::CMD_FWD, $urandom, $urandom);
        send_cmd(dll_pkg::CMD_BWD, $urandom, $urandom);
        // Duplicates: insert and delete act on the first match from the head.
        send_cmd(dll_pkg::CMD_APPEND, 32'sd5, $urandom);
        send_cmd(dll_pkg::CMD_APPEND, 32'sd5, $urandom);
        send_cmd(dll_pkg::CMD_INSERT, 32'sd6, 32'sd5);
        send_cmd(dll_pkg::CMD_DELETE, 32'sd5, $urandom);
        send_cmd(dll_pkg::CMD_DELETE, VAL_MIN, $urandom);
        send_cmd(dll_pkg::CMD_DELETE, 32'sd5, $urandom);
        send_cmd(CMD_SPARE_A, $urandom, $urandom);
        send_cmd(CMD_SPARE_B, $urandom, $urandom);
        send_cmd(dll_pkg::CMD_BWD, $urandom, $urandom);
    endtask

    // Fill the pool, hit every full case, walk a full list, then empty it.
    task automatic test_fill_and_drain();
        int r;
        sink_stalls_on = 1'b1;
        src_gaps_on = 1'b0;
        while (mirror_list.size() < POOL)
        begin
            r = $urandom_range(0, 2);
            if (r == 0)
                send_cmd(dll_pkg::CMD_APPEND, pick_value(), $urandom);
            else if (r == 1)
                send_cmd(dll_pkg::CMD_PREPEND, pick_value(), $urandom);
            else
                send_cmd(dll_pkg::CMD_INSERT, pick_value(), pick_present());
        end
        send_cmd(dll_pkg::CMD_APPEND, pick_value(), $urandom);
        send_cmd(dll_pkg::CMD_PREPEND, pick_value(), $urandom);
        send_cmd(dll_pkg::CMD_INSERT, pick_value(), mirror_list[$urandom_range(0, POOL - 1)]);
        send_cmd(dll_pkg::CMD_INSERT, pick_value(), pick_absent());
        send_cmd(dll_pkg::CMD_FWD, $urandom, $urandom);
        send_cmd(dll_pkg::CMD_BWD, $urandom, $urandom);
        src_gaps_on = 1'b1;
        while (mirror_list.size() != 0)
        begin
            send_cmd(dll_pkg::CMD_DELETE,
                     mirror_list[$urandom_range(0, mirror_list.size() - 1)], $urandom);
            if ($urandom_range(0, 7) == 0)
                send_cmd($urandom_range(0, 1) ? dll_pkg::CMD_FWD : dll_pkg::CMD_BWD,
                         $urandom, $urandom);
        end
        send_cmd(dll_pkg::CMD_FWD, $urandom, $urandom);
    endtask

    // Weighted random commands, keys and delete values mostly taken from the list.
    task automatic test_random_mix();
        int n;
        int r;
        n = 0;
        while (n < MIX_ITEMS)
        begin
            if (n % 20 == 0)
            begin
                src_gaps_on = $urandom_range(0, 2) != 0;
                sink_stalls_on = $urandom_range(0, 2) != 0;
            end
            r = $urandom_range(0, 99);
            if (r < 22)
                send_cmd(dll_pkg::CMD_APPEND, pick_value(), $urandom);
            else if (r < 38)
                send_cmd(dll_pkg::CMD_PREPEND, pick_value(), $urandom);
            else if (r < 58)
                send_cmd(dll_pkg::CMD_INSERT, pick_value(), pick_present());
            else if (r < 80)
                send_cmd(dll_pkg::CMD_DELETE, pick_present(), $urandom);
            else if (r < 88)
                send_cmd(dll_pkg::CMD_FWD, $urandom, $urandom);
            else if (r < 96)
                send_cmd(dll_pkg::CMD_BWD, $urandom, $urandom);
            else
            begin
                send_cmd($urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B, $urandom, $urandom);
                continue;
            end
            n++;
        end
    endtask

    // Output back-pressure: random stalls while enabled.
    initial
    begin
        int stall_left;
        out_ready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready = 1'b1;
                if (sink_stalls_on && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    function automatic void flag_field(input string field, input int want_v, input int got_v);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
            $error("%s mismatch: expected %0d, got %0d", field, want_v, got_v);
    endfunction

    // Compare each reply beat against the oldest expected one.
    always @(posedge clk)
    begin : check_replies
        dll_pkg::out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            beats_checked++;
            if (expected_replies.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= MAX_REPORTS)
                    $error("reply beat with nothing expected: status %0d item %0d",
                           out_beat.status, out_beat.item);
            end
            else
            begin
                want = expected_replies.pop_front();
                case (want.status)
                    dll_pkg::ST_FULL: full_seen++;
                    dll_pkg::ST_NOT_FOUND: missing_seen++;
                    dll_pkg::ST_EMPTY: empty_seen++;
                    default: ;
                endcase
                if (out_beat.status !== want.status)
                    flag_field("status", int'(want.status), int'(out_beat.status));
                if (out_beat.item !== want.item)
                    flag_field("item", want.item, out_beat.item);
                if (out_beat.last !== want.last)
                    flag_field("last", int'(want.last), int'(out_beat.last));
                if (out_beat.count !== want.count)
                    flag_field("count", int'(want.count), int'(out_beat.count));
            end
        end
    end

    // Reset, run the tests, drain and report.
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_beat = '0;
        src_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_list();
        test_directed_edits();
        test_fill_and_drain();
        test_random_mix();
        stop_sending();

        // Let outstanding replies arrive, then allow a full pass for stray beats.
        sink_stalls_on = 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (POOL + 8) @(posedge clk);
        if (expected_replies.size() != 0)
        begin
            fail_cnt++;
            $error("%0d reply beats never arrived", expected_replies.size());
        end

        $display("Covered %0d commands and %0d reply beats (%0d full, %0d not found, %0d empty).",
                 cmds_sent, beats_checked, full_seen, missing_seen, empty_seen);
        if (fail_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
